FILE: hdl/mh64a_pkg.sv
// Package for the 64-bit MurmurHash2 (64A) core.
// Holds the sequencer state type and the mixing constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mh64a_pkg;

    // Mixing multiplier and shift distance
    localparam logic [63:0] C_MIX_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned C_MIX_R = 47;

    // Sequencer states; every state but the first two drives the shared multiplier
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEED,
        S_MIX1,
        S_MIX2,
        S_HMUL,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/murmur2_hash_64a_top.sv
// Top level of the 64-bit MurmurHash2 (64A) core: sequencer, shared 32x32 multiplier,
// seed register and output register. Depends on mh64a_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                     Payload
// in        to core    i_in_valid / o_in_stall       i_data_word, i_byte_count, i_key_length,
//                                                    i_first_word, i_last_word
// out       from core  o_out_valid / i_out_stall     o_hash_value
// cfg       to core    i_cfg_valid / o_cfg_ready     i_cfg_seed
//
// Every 64-bit multiply by the mixing constant is done in partial products on one 32x32 multiplier.
// Per word: accept; seed multiply (first word) or S_START (other); mix, mix, hash multiply (full),
// hash multiply (partial) or none (empty); and a final multiply on a last word.
// The core holds o_in_stall high from acceptance until the word is done.
// A finished hash waits in the output register; the final multiply holds while it is full.
// Reset is synchronous: seed and running hash clear to zero.
module murmur2_hash_64a_top
    import mh64a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic [30:0] i_key_length,
    input  wire logic        i_first_word,
    input  wire logic        i_last_word,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_hash_value,
    // seed write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_seed
);

    // Control and data registers
    t_state      r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [63:0] r_acc,   n_acc;
    logic [63:0] r_mop,   n_mop;
    logic [63:0] r_hash,  n_hash;
    logic [63:0] r_word,  n_word;
    logic [3:0]  r_count, n_count;
    logic        r_last,  n_last;
    logic [31:0] r_seed;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out,   n_out;

    // Shared multiplier signals
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] mul_res;
    logic        is_mul;
    logic        out_free;
    logic        step;
    logic        done;

    // Dispatch helpers
    logic [63:0] h_src;
    logic [63:0] tail_mask;
    logic [63:0] tail_hash;
    logic [63:0] mix_x;
    logic        in_acc;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;

    // Pick the partial product for this phase: lo*lo, lo*hi, hi*lo
    always_comb begin
        unique case (r_phase)
            2'd0: begin
                mul_a = r_mop[31:0];
                mul_b = C_MIX_M[31:0];
            end
            2'd1: begin
                mul_a = r_mop[31:0];
                mul_b = C_MIX_M[63:32];
            end
            default: begin
                mul_a = r_mop[63:32];
                mul_b = C_MIX_M[31:0];
            end
        endcase
    end

    assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_res = {r_acc[63:32] + prod[31:0], r_acc[31:0]};

    assign is_mul = (r_state == S_SEED) || (r_state == S_MIX1) || (r_state == S_MIX2)
                 || (r_state == S_HMUL) || (r_state == S_FIN);
    // hold the final multiply while the output register is still full
    assign step = is_mul && !((r_state == S_FIN) && (r_phase == 2'd2) && !out_free);
    assign done = step && (r_phase == 2'd2);

    // Hash entering the word: freshly seeded or carried over
    assign h_src     = (r_state == S_SEED) ? ({32'd0, r_seed} ^ mul_res) : r_hash;
    assign tail_mask = ~(64'hffff_ffff_ffff_ffff << {r_count[2:0], 3'b000});
    assign tail_hash = h_src ^ (r_word & tail_mask);
    assign mix_x     = r_hash ^ mul_res;

    // Next state, multiplier accumulate and hash updates
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_mop       = r_mop;
        n_hash      = r_hash;
        n_word      = r_word;
        n_count     = r_count;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        // advance the multiplier
        if (step) begin
            unique case (r_phase)
                2'd0:    n_acc = prod;
                2'd1:    n_acc = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
                default: n_acc = r_acc;
            endcase
            n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_word  = i_data_word;
                    n_count = i_byte_count[3] ? 4'd8 : i_byte_count;
                    n_last  = i_last_word;
                    n_mop   = {33'd0, i_key_length};
                    n_phase = 2'd0;
                    n_state = i_first_word ? S_SEED : S_START;
                end
            end
            S_START, S_SEED: begin
                if ((r_state == S_START) || done) begin
                    priority if (r_count == 4'd8) begin
                        n_hash  = h_src;
                        n_mop   = r_word;
                        n_state = S_MIX1;
                    end else if (r_count != 4'd0) begin
                        n_hash  = tail_hash;
                        n_mop   = tail_hash;
                        n_state = S_HMUL;
                    end else if (r_last) begin
                        n_hash  = h_src;
                        n_mop   = h_src ^ (h_src >> C_MIX_R);
                        n_state = S_FIN;
                    end else begin
                        n_hash  = h_src;
                        n_state = S_IDLE;
                    end
                end
            end
            S_MIX1: begin
                if (done) begin
                    n_mop   = mul_res ^ (mul_res >> C_MIX_R);
                    n_state = S_MIX2;
                end
            end
            S_MIX2: begin
                if (done) begin
                    n_hash  = mix_x;
                    n_mop   = mix_x;
                    n_state = S_HMUL;
                end
            end
            S_HMUL: begin
                if (done) begin
                    n_hash = mul_res;
                    if (r_last) begin
                        n_mop   = mul_res ^ (mul_res >> C_MIX_R);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (done) begin
                    n_out       = mul_res ^ (mul_res >> C_MIX_R);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and running hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 2'd0;
            r_out_valid <= 1'b0;
            r_hash      <= 64'd0;
            r_seed      <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_mop   <= n_mop;
        r_word  <= n_word;
        r_count <= n_count;
        r_last  <= n_last;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire
